### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pts_pkg
// Shared types, codes and default sizes for the priority task scheduler.
// ============================================================================
package pts_pkg;

  // Default sizes of the task table and of the stored fields.
  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Tick count loaded at reset.
  localparam int unsigned RESET_TIME = 10;

  // Fixed widths of the beat fields.
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned PRIO_IN_W = 8;
  localparam int unsigned TIME_IO_W = 32;
  localparam int unsigned ID_OUT_W  = 4;
  localparam int unsigned STATUS_W  = 2;

  // Request codes carried by req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER    = 3'd0,
    REQ_START       = 3'd1,
    REQ_TICK        = 3'd2,
    REQ_SLEEP       = 3'd3,
    REQ_SLEEP_UNTIL = 3'd4
  } req_e;

  // Status codes returned with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_TABLE_FULL  = 2'd1,
    ST_NOT_STARTED = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_CHECK,
    SEQ_SCAN
  } seq_state_e;

endpackage

### rtl/pts_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/priority_task_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// priority_task_scheduler
// Preemptive priority scheduler with a task table, a tick counter and a
// sequential winner scan over the table.
// ============================================================================
// Usage:
// Requests arrive as beats on the input channel (in_valid_i / in_stall_o) and
// every accepted beat returns exactly one result beat on the output channel
// (out_valid_o / out_stall_i). A beat moves when valid is high and stall low.
// Register, start, unknown codes and requests refused before start answer
// directly: the result is in the output register after the accepting edge.
// A tick or a sleep runs a reschedule: the accepting cycle updates the time or
// the active task's wake time, SEQ_FETCH reads that wake time and the start
// candidate's priority, SEQ_CHECK fixes an overdue wake time, then SEQ_SCAN
// steps through the registered tasks with the single compare unit, finishes
// the last compare and loads the result. The table RAMs have one read port
// each, which sets the pace of the scan.
// One request is in work at a time; the input stalls while the sequencer is
// busy or while an unaccepted result blocks the output register.
// Reset empties the task table, stops the scheduler and sets the time to ten;
// table entries are not cleared and are only read once registered.
// A stalled result holds its value until the receiver takes it.
// ============================================================================
module priority_task_scheduler #(
  parameter int unsigned MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int unsigned PRIO_BITS = pts_pkg::PRIO_BITS_DEF,
  parameter int unsigned TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pts_pkg::REQ_W-1:0]     req_type_i,
  input  logic [pts_pkg::PRIO_IN_W-1:0] new_priority_i,
  input  logic [pts_pkg::TIME_IO_W-1:0] time_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pts_pkg::ID_OUT_W-1:0]  active_task_o,
  output logic                          switched_o,
  output logic [pts_pkg::ID_OUT_W-1:0]  assigned_id_o,
  output logic [pts_pkg::TIME_IO_W-1:0] time_now_o,
  output logic [pts_pkg::STATUS_W-1:0]  status_o
);

  import pts_pkg::*;

  localparam int unsigned ID_W  = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // Control state.
  seq_state_e           state_q, state_d;
  logic [CNT_W-1:0]     task_count_q, task_count_d;
  logic [ID_W-1:0]      active_q, active_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 running_q, running_d;
  logic                 out_valid_q, out_valid_d;

  // Sequencer working registers.
  logic                 after_sleep_q, after_sleep_d;
  logic [ID_W-1:0]      old_active_q, old_active_d;
  logic [ID_W-1:0]      best_q, best_d;
  logic [PRIO_BITS-1:0] best_prio_q, best_prio_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [ID_W-1:0]      cmp_idx_q, cmp_idx_d;

  // Result register.
  logic [ID_W-1:0]      res_active_q, res_active_d;
  logic                 res_switched_q, res_switched_d;
  logic [ID_W-1:0]      res_assigned_q, res_assigned_d;
  logic [TIME_BITS-1:0] res_time_q, res_time_d;
  status_e              res_status_q, res_status_d;
  logic                 res_load;

  // Table RAM ports.
  logic                 prio_we;
  logic                 wake_we;
  logic [ID_W-1:0]      prio_waddr;
  logic [ID_W-1:0]      wake_waddr;
  logic [PRIO_BITS-1:0] prio_wdata;
  logic [TIME_BITS-1:0] wake_wdata;
  logic [ID_W-1:0]      prio_raddr;
  logic [ID_W-1:0]      wake_raddr;
  logic [PRIO_BITS-1:0] prio_rdata;
  logic [TIME_BITS-1:0] wake_rdata;

  // Input fields brought to the stored widths.
  logic [PRIO_BITS+PRIO_IN_W-1:0] prio_ext;
  logic [TIME_BITS+TIME_IO_W-1:0] tval_ext;
  logic [PRIO_BITS-1:0]           prio_in;
  logic [TIME_BITS-1:0]           tval_in;

  logic in_accept;
  logic scan_done;
  logic table_full;

  assign prio_ext = {{PRIO_BITS{1'b0}}, new_priority_i};
  assign tval_ext = {{TIME_BITS{1'b0}}, time_value_i};
  assign prio_in  = prio_ext[PRIO_BITS-1:0];
  assign tval_in  = tval_ext[TIME_BITS-1:0];

  // Input is taken only by an idle sequencer with room in the output register.
  assign in_stall_o = (state_q != SEQ_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign table_full = (task_count_q == CNT_W'(MAX_TASKS));
  assign scan_done  = !cmp_vld_q && (rd_idx_q == task_count_q);

  // Task table memories.
  pts_ram #(
    .WIDTH (PRIO_BITS),
    .DEPTH (MAX_TASKS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (prio_waddr),
    .wdata_i (prio_wdata),
    .raddr_i (prio_raddr),
    .rdata_o (prio_rdata)
  );

  pts_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_TASKS)
  ) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (wake_we),
    .waddr_i (wake_waddr),
    .wdata_i (wake_wdata),
    .raddr_i (wake_raddr),
    .rdata_o (wake_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SEQ_IDLE;
      task_count_q  <= '0;
      active_q      <= '0;
      time_q        <= TIME_BITS'(RESET_TIME);
      running_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      after_sleep_q <= 1'b0;
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      task_count_q  <= task_count_d;
      active_q      <= active_d;
      time_q        <= time_d;
      running_q     <= running_d;
      out_valid_q   <= out_valid_d;
      after_sleep_q <= after_sleep_d;
      rd_idx_q      <= rd_idx_d;
      cmp_vld_q     <= cmp_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    old_active_q   <= old_active_d;
    best_q         <= best_d;
    best_prio_q    <= best_prio_d;
    cmp_idx_q      <= cmp_idx_d;
    res_active_q   <= res_active_d;
    res_switched_q <= res_switched_d;
    res_assigned_q <= res_assigned_d;
    res_time_q     <= res_time_d;
    res_status_q   <= res_status_d;
  end

  // Sequencer: request decode, reschedule steps and result capture.
  always_comb begin
    state_d        = state_q;
    task_count_d   = task_count_q;
    active_d       = active_q;
    time_d         = time_q;
    running_d      = running_q;
    after_sleep_d  = after_sleep_q;
    old_active_d   = old_active_q;
    best_d         = best_q;
    best_prio_d    = best_prio_q;
    rd_idx_d       = rd_idx_q;
    cmp_vld_d      = 1'b0;
    cmp_idx_d      = cmp_idx_q;
    prio_we        = 1'b0;
    wake_we        = 1'b0;
    prio_waddr     = task_count_q[ID_W-1:0];
    wake_waddr     = active_q;
    prio_wdata     = prio_in;
    wake_wdata     = '0;
    prio_raddr     = rd_idx_q[ID_W-1:0];
    wake_raddr     = rd_idx_q[ID_W-1:0];
    res_load       = 1'b0;
    res_active_d   = res_active_q;
    res_switched_d = res_switched_q;
    res_assigned_d = res_assigned_q;
    res_time_d     = res_time_q;
    res_status_d   = res_status_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (in_accept) begin
          old_active_d   = active_q;
          res_active_d   = active_q;
          res_switched_d = 1'b0;
          res_assigned_d = '0;
          res_time_d     = time_q;
          res_status_d   = ST_OK;
          unique case (req_type_i)
            REQ_REGISTER: begin
              res_load = 1'b1;
              if (table_full) begin
                res_status_d = ST_TABLE_FULL;
              end else begin
                prio_we        = 1'b1;
                wake_we        = 1'b1;
                wake_waddr     = task_count_q[ID_W-1:0];
                wake_wdata     = '0;
                res_assigned_d = task_count_q[ID_W-1:0];
                task_count_d   = task_count_q + CNT_W'(1);
              end
            end
            REQ_START: begin
              res_load = 1'b1;
              if (task_count_q == '0) begin
                res_status_d = ST_NOT_STARTED;
              end else begin
                running_d      = 1'b1;
                active_d       = '0;
                res_active_d   = '0;
                res_switched_d = (active_q != '0);
              end
            end
            REQ_TICK, REQ_SLEEP, REQ_SLEEP_UNTIL: begin
              if (!running_q || (task_count_q == '0)) begin
                res_load     = 1'b1;
                res_status_d = ST_NOT_STARTED;
              end else begin
                state_d = SEQ_FETCH;
                if (req_type_i == REQ_TICK) begin
                  after_sleep_d = 1'b0;
                  time_d        = time_q + TIME_BITS'(1);
                end else begin
                  after_sleep_d = 1'b1;
                  wake_we       = 1'b1;
                  wake_waddr    = active_q;
                  wake_wdata    = (req_type_i == REQ_SLEEP) ? (time_q + tval_in) : tval_in;
                end
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      // Read the active task's wake time and the start candidate's priority.
      SEQ_FETCH: begin
        wake_raddr = active_q;
        prio_raddr = after_sleep_q ? '0 : active_q;
        best_d     = after_sleep_q ? '0 : active_q;
        state_d    = SEQ_CHECK;
      end

      // Push an overdue wake time to the next tick and arm the scan.
      SEQ_CHECK: begin
        best_prio_d = prio_rdata;
        if (wake_rdata < time_q) begin
          wake_we    = 1'b1;
          wake_waddr = active_q;
          wake_wdata = time_q + TIME_BITS'(1);
        end
        rd_idx_d = '0;
        state_d  = SEQ_SCAN;
      end

      // One table entry is read and one is compared in every cycle.
      SEQ_SCAN: begin
        if (rd_idx_q != task_count_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[ID_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end
        if (cmp_vld_q && (wake_rdata <= time_q) && (prio_rdata > best_prio_q)) begin
          best_d      = cmp_idx_q;
          best_prio_d = prio_rdata;
        end
        if (scan_done) begin
          active_d       = best_q;
          res_load       = 1'b1;
          res_active_d   = best_q;
          res_switched_d = (best_q != old_active_q);
          res_assigned_d = '0;
          res_time_d     = time_q;
          res_status_d   = ST_OK;
          state_d        = SEQ_IDLE;
        end
      end

      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Result fields brought to the port widths.
  logic [ID_W+ID_OUT_W-1:0]      active_ext;
  logic [ID_W+ID_OUT_W-1:0]      assigned_ext;
  logic [TIME_BITS+TIME_IO_W-1:0] time_ext;

  assign active_ext   = {{ID_OUT_W{1'b0}}, res_active_q};
  assign assigned_ext = {{ID_OUT_W{1'b0}}, res_assigned_q};
  assign time_ext     = {{TIME_IO_W{1'b0}}, res_time_q};

  assign out_valid_o   = out_valid_q;
  assign active_task_o = active_ext[ID_OUT_W-1:0];
  assign switched_o    = res_switched_q;
  assign assigned_id_o = assigned_ext[ID_OUT_W-1:0];
  assign time_now_o    = time_ext[TIME_IO_W-1:0];
  assign status_o      = res_status_q;

  // The active task is always a registered one once the scheduler runs.
  a_active_registered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (CNT_W'(active_q) < task_count_q))
    else $error("active task outside the registered range");

  // The task count never passes the table size.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    task_count_q <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  // A finished scan always finds the output register free.
  a_scan_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SCAN && scan_done) |-> !out_valid_q)
    else $error("scan result would overwrite a pending beat");

  // The scan read pointer stays within the registered tasks.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SCAN) |-> (rd_idx_q <= task_count_q))
    else $error("scan pointer beyond task count");

  // A reschedule only starts when the scheduler is running.
  a_resched_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_FETCH) |-> (running_q && (task_count_q != '0)))
    else $error("reschedule without running scheduler");

endmodule

### sim/pts_sched_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pts_sched_checker
// Watches both channels of the priority task scheduler, predicts the result
// of every accepted request beat and compares it with the result beats.
// ============================================================================
module pts_sched_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [pts_pkg::REQ_W-1:0]     req_type_i,
  input  logic [pts_pkg::PRIO_IN_W-1:0] new_priority_i,
  input  logic [pts_pkg::TIME_IO_W-1:0] time_value_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [pts_pkg::ID_OUT_W-1:0]  active_task_o,
  input  logic                          switched_o,
  input  logic [pts_pkg::ID_OUT_W-1:0]  assigned_id_o,
  input  logic [pts_pkg::TIME_IO_W-1:0] time_now_o,
  input  logic [pts_pkg::STATUS_W-1:0]  status_o,
  output int                            fail_count_o,
  output int                            pending_o
);

  import pts_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_TASKS_DEF;

  // One predicted result beat.
  typedef struct packed {
    logic [ID_OUT_W-1:0]  active;
    logic                 switched;
    logic [ID_OUT_W-1:0]  assigned_id;
    logic [TIME_IO_W-1:0] now;
    status_e              status;
  } sched_answer_t;

  // Private copy of the scheduler state.
  logic [PRIO_BITS_DEF-1:0] prio_tbl [TABLE_DEPTH];
  logic [TIME_BITS_DEF-1:0] wake_tbl [TABLE_DEPTH];
  logic [4:0]               n_tasks;
  logic [ID_OUT_W-1:0]      runner_id;
  logic [TIME_BITS_DEF-1:0] ticks;
  logic                     started;

  sched_answer_t answers_q [$];
  int            mismatches;

  // Moves an overdue wake time of the running task forward, then scans the
  // table for the ready task with the highest priority.
  function automatic void pick_runner(input bit after_sleep);
    logic [ID_OUT_W-1:0] best;
    if (wake_tbl[runner_id] < ticks) begin
      wake_tbl[runner_id] = ticks + 1'b1;
    end
    best = after_sleep ? '0 : runner_id;
    for (int i = 0; i < int'(n_tasks); i++) begin
      if (wake_tbl[i] <= ticks && prio_tbl[i] > prio_tbl[best]) begin
        best = i[ID_OUT_W-1:0];
      end
    end
    runner_id = best;
  endfunction

  // Applies one request to the state and returns the result it causes.
  function automatic sched_answer_t predict_answer(input logic [REQ_W-1:0] code,
                                                   input logic [PRIO_IN_W-1:0] prio,
                                                   input logic [TIME_IO_W-1:0] tval);
    sched_answer_t       ans;
    logic [ID_OUT_W-1:0] prev;
    prev            = runner_id;
    ans.assigned_id = '0;
    ans.status      = ST_OK;
    case (code)
      REQ_REGISTER: begin
        if (n_tasks >= TABLE_DEPTH) begin
          ans.status = ST_TABLE_FULL;
        end else begin
          prio_tbl[n_tasks[3:0]] = prio;
          wake_tbl[n_tasks[3:0]] = '0;
          ans.assigned_id        = n_tasks[3:0];
          n_tasks                = n_tasks + 1'b1;
        end
      end
      REQ_START: begin
        if (n_tasks == 0) begin
          ans.status = ST_NOT_STARTED;
        end else begin
          started   = 1'b1;
          runner_id = '0;
        end
      end
      REQ_TICK, REQ_SLEEP, REQ_SLEEP_UNTIL: begin
        if (!started || n_tasks == 0) begin
          ans.status = ST_NOT_STARTED;
        end else if (code == REQ_TICK) begin
          ticks = ticks + 1'b1;
          pick_runner(1'b0);
        end else begin
          wake_tbl[runner_id] = (code == REQ_SLEEP) ? ticks + tval : tval;
          pick_runner(1'b1);
        end
      end
      default: begin
        // Unknown codes leave the state alone and answer with status OK.
      end
    endcase
    ans.active   = runner_id;
    ans.switched = (runner_id != prev);
    ans.now      = ticks;
    return ans;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, seen);
      mismatches++;
    end
  endtask

  // Result beats are compared before the new request beat is predicted, so a
  // result always meets an older expectation.
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    sched_answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        prio_tbl[i] = '0;
        wake_tbl[i] = '0;
      end
      n_tasks      = '0;
      runner_id    = '0;
      ticks        = RESET_TIME;
      started      = 1'b0;
      mismatches   = 0;
      answers_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t ns: result beat with no request waiting, expected none, actual %0d",
                   $time, active_task_o);
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          check_field("active_task", 32'(want.active), 32'(active_task_o));
          check_field("switched", 32'(want.switched), 32'(switched_o));
          check_field("assigned_id", 32'(want.assigned_id), 32'(assigned_id_o));
          check_field("time_now", 32'(want.now), 32'(time_now_o));
          check_field("status", 32'(want.status), 32'(status_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        answers_q.push_back(predict_answer(req_type_i, new_priority_i, time_value_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= answers_q.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus and verdict for the priority task scheduler: directed requests
// around start and sleeps, then random request beats with rare registrations,
// with random idling on both channels and one long hold-off at the output.
// ============================================================================
module tb;
  import pts_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i;
  logic [PRIO_IN_W-1:0]  new_priority_i;
  logic [TIME_IO_W-1:0]  time_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ID_OUT_W-1:0]   active_task_o;
  logic                  switched_o;
  logic [ID_OUT_W-1:0]   assigned_id_o;
  logic [TIME_IO_W-1:0]  time_now_o;
  logic [STATUS_W-1:0]   status_o;

  int                    fail_count;
  int                    pending;
  int                    idle_cycles;
  logic                  no_idle;
  logic                  hold_req;
  logic                  hold_done;
  logic                  clock_running;
  logic [TIME_IO_W-1:0]  sched_time;

  priority_task_scheduler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .new_priority_i (new_priority_i),
    .time_value_i   (time_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .active_task_o  (active_task_o),
    .switched_o     (switched_o),
    .assigned_id_o  (assigned_id_o),
    .time_now_o     (time_now_o),
    .status_o       (status_o)
  );

  pts_sched_checker sched_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .new_priority_i (new_priority_i),
    .time_value_i   (time_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .active_task_o  (active_task_o),
    .switched_o     (switched_o),
    .assigned_id_o  (assigned_id_o),
    .time_now_o     (time_now_o),
    .status_o       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request beat and waits at clock edges until the input stall is low.
  task automatic offer_request(input logic [REQ_W-1:0] code,
                               input logic [PRIO_IN_W-1:0] prio,
                               input logic [TIME_IO_W-1:0] tval);
    int unsigned gap;
    gap = (hold_req && !hold_done) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= code;
    new_priority_i <= prio;
    time_value_i   <= tval;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (code == REQ_TICK && clock_running) begin
      sched_time = sched_time + 1'b1;
    end
  endtask

  // Result side: random stall stretches, plus one long hold-off on request.
  initial begin : result_side
    int unsigned n;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too many cycles in a row without any beat ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : request_side
    int unsigned       r;
    logic [REQ_W-1:0]  code;
    logic [PRIO_IN_W-1:0] prio;
    logic [TIME_IO_W-1:0] tval;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_REGISTER;
    new_priority_i = '0;
    time_value_i   = '0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    clock_running  = 1'b0;
    sched_time     = RESET_TIME;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks and sleeps before start and a start with no task are refused.
    offer_request(REQ_TICK, 8'h00, 32'h0000_0000);
    offer_request(REQ_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    offer_request(REQ_SLEEP_UNTIL, 8'h00, 32'h0000_0005);
    offer_request(REQ_START, 8'h00, 32'h0000_0000);
    offer_request(REQ_UNKNOWN_FIRST, 8'hFF, 32'hFFFF_FFFF);
    offer_request(REQ_UNKNOWN_FIRST + 3'd1, 8'h55, 32'hAAAA_AAAA);
    offer_request(REQ_UNKNOWN_LAST, 8'hAA, 32'h5555_5555);
    offer_request(REQ_REGISTER, 8'h00, 32'hFFFF_FFFF);
    offer_request(REQ_REGISTER, 8'hFF, 32'h0000_0000);
    offer_request(REQ_REGISTER, 8'h80, 32'h0000_0000);
    offer_request(REQ_TICK, 8'h00, 32'h0000_0000);
    offer_request(REQ_START, 8'h00, 32'h0000_0000);
    clock_running = 1'b1;
    // Preemption by the top priority, then sleeps that hand the slot around.
    offer_request(REQ_TICK, 8'h00, 32'h0000_0000);
    offer_request(REQ_SLEEP, 8'h00, 32'h0000_0005);
    offer_request(REQ_SLEEP_UNTIL, 8'h00, 32'h0000_0000);
    // A duration that wraps behind the present time counts as overdue.
    offer_request(REQ_SLEEP, 8'h00, 32'hFFFF_FFFF);
    offer_request(REQ_SLEEP_UNTIL, 8'h00, 32'hFFFF_FFFF);
    repeat (3) offer_request(REQ_TICK, 8'h00, 32'h0000_0000);
    offer_request(REQ_REGISTER, 8'h7F, 32'h0000_0000);
    offer_request(REQ_START, 8'h00, 32'h0000_0000);
    offer_request(REQ_TICK, 8'h00, 32'h0000_0000);
    offer_request(REQ_SLEEP, 8'h00, 32'h0000_0000);
    offer_request(REQ_TICK, 8'h00, 32'h0000_0000);

    // Random requests: mostly ticks and sleeps with short waits so that tasks
    // wake up again; registers are rare so the table fills part way through.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 300 && i < 400) || (i >= 850 && i < 900);
      if (i == 600) hold_req = 1'b1;
      r    = $urandom_range(0, 99);
      prio = PRIO_IN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 255));
      tval = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 12);
      if (r < 3) begin
        code = REQ_REGISTER;
      end else if (r < 5) begin
        code = REQ_START;
      end else if (r < 8) begin
        code = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      end else if (r < 52) begin
        code = REQ_TICK;
      end else if (r < 78) begin
        code = REQ_SLEEP;
      end else begin
        code = REQ_SLEEP_UNTIL;
        // Wake times near the present, some of them already past.
        if ($urandom_range(0, 4) < 3) tval = sched_time + $urandom_range(0, 16) - 4;
      end
      offer_request(code, prio, tval);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    // Drain, then give the block time to show any stray result beat. The
    // pending count is registered, so it is read at the edge after the last beat.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
